// ----- design/bstr_pkg.sv -----
// Shared types, widths and constants of the blocked stencil / torus rank map.
// No dependencies; every other design file but bstr_div_pipe refers to this package by scoped names.
package bstr_pkg;

    // Field widths
    localparam int IDX_W      = 20;
    localparam int STENCIL_W  = 24;
    localparam int TRANK_W    = 20;
    localparam int RC_W       = 20;
    localparam int GRID_W     = 9;
    localparam int BLK_W      = 7;

    // Stencil grouping: GROUP_EDGE^3 blocks per group
    localparam int GROUP_EDGE = 4;
    localparam int GROUP_BITS = 2;
    localparam int CUBE_BITS  = 3 * GROUP_BITS;

    // Derived configuration widths
    localparam int GC_W       = 7;                   // groups per axis, blocks >= 1
    localparam int BXY_W      = 2 * BLK_W;
    localparam int CELLS_W    = 3 * BLK_W;
    localparam int GROUP_W    = CELLS_W + CUBE_BITS;
    localparam int GXY_W      = 2 * GC_W;
    localparam int GXGY_W     = 2 * GRID_W;
    localparam int GNUM_W     = IDX_W - CUBE_BITS;   // group size is at least 64

    // 6-D torus walk
    localparam int TORUS_SIDE     = 6;
    localparam int TORUS_HALF     = (TORUS_SIDE + 1) / 2;
    localparam int TORUS_DIMS     = 6;
    localparam int RANKS_PER_NODE = 16;
    localparam int SLOT_BITS      = 4;
    localparam int SUB_LO         = SLOT_BITS + TORUS_DIMS;
    localparam int SUB_W          = IDX_W - SUB_LO;
    localparam int NODE_W         = TRANK_W - SLOT_BITS;
    localparam int TORUS_TOTAL    = (TORUS_HALF ** TORUS_DIMS) << SUB_LO;
    localparam int DIV3_MUL       = 683;
    localparam int DIV3_SHIFT     = 11;

    // Cycles for the derived configuration to settle after a register write
    localparam int SETTLE_CYCLES  = 12;
    localparam int SETTLE_W       = 4;

    // Register map
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_RANK_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_X     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRID_Y     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GRID_Z     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_X    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_Y    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_Z    = 3'd6;

    typedef struct packed {
        logic [RC_W-1:0]    rank_count;
        logic [GRID_W-1:0]  grid_x;
        logic [GXGY_W-1:0]  grid_xy;
        logic [BLK_W-1:0]   blk_x;
        logic [BLK_W-1:0]   blk_y;
        logic [BLK_W-1:0]   blk_z;
        logic [BXY_W-1:0]   blk_xy;
        logic [CELLS_W-1:0] cells;
        logic [GC_W-1:0]    gc_x;
        logic [GXY_W-1:0]   gc_xy;
        logic               bad;
    } cfg_t;

    function automatic int pow6(input int e);
        int r;
        r = 1;
        for (int m = 0; m < e; m++) begin
            r = r * TORUS_SIDE;
        end
        return r;
    endfunction

endpackage

// ----- design/bstr_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the divisor must stay stable while transactions are in flight.
module bstr_div_pipe #(
    parameter int Q  = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_hi,
    input  logic [Q-1:0]  in_lo,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [Q-1:0]  quot,
    output logic [DW-1:0] rem,
    output logic [PW-1:0] out_pay
);

    logic          valid_reg [Q];
    logic [DW-1:0] rem_reg   [Q];
    logic [Q-1:0]  lo_reg    [Q];
    logic [PW-1:0] pay_reg   [Q];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic          vin;
        logic [DW-1:0] rin;
        logic [Q-1:0]  lin;
        logic [PW-1:0] pin;
        logic [DW:0]   trial;
        logic          take;
        logic [Q:0]    shifted;
        logic [DW-1:0] rem_next;
        logic [Q-1:0]  lo_next;

        if (k == 0) begin : g_first
            assign vin = in_valid;
            assign rin = in_hi;
            assign lin = in_lo;
            assign pin = in_pay;
        end else begin : g_rest
            assign vin = valid_reg[k-1];
            assign rin = rem_reg[k-1];
            assign lin = lo_reg[k-1];
            assign pin = pay_reg[k-1];
        end

        // Bring down the next dividend bit, subtract when it fits
        assign trial    = {rin, lin[Q-1]};
        assign take     = (trial >= {1'b0, den});
        assign rem_next = take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        assign shifted  = {lin, take};
        assign lo_next  = shifted[Q-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            lo_reg[k]  <= lo_next;
            pay_reg[k] <= pin;
        end
    end

    assign out_valid = valid_reg[Q-1];
    assign quot      = lo_reg[Q-1];
    assign rem       = rem_reg[Q-1];
    assign out_pay   = pay_reg[Q-1];

endmodule

// ----- design/bstr_torus.sv -----
// Six-stage pipeline mapping a task index to its 6-D torus rank, one axis digit per stage.
// Depends on bstr_pkg.
module bstr_torus (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bstr_pkg::IDX_W-1:0]  in_idx,
    input  logic                        in_bad,
    output logic                        out_valid,
    output logic [bstr_pkg::IDX_W-1:0]  out_idx,
    output logic                        out_bad,
    output logic [bstr_pkg::TRANK_W-1:0] out_trank
);

    localparam int N = bstr_pkg::TORUS_DIMS;

    logic                            valid_reg [N];
    logic [bstr_pkg::SUB_W-1:0]      sub_reg   [N];
    logic [bstr_pkg::NODE_W-1:0]     acc_reg   [N];
    logic [bstr_pkg::IDX_W-1:0]      idx_reg   [N];
    logic                            bad_reg   [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic                                        vin;
        logic [bstr_pkg::SUB_W-1:0]                  sin;
        logic [bstr_pkg::NODE_W-1:0]                 ain;
        logic [bstr_pkg::IDX_W-1:0]                  iin;
        logic                                        bin;
        logic [bstr_pkg::SUB_W+bstr_pkg::DIV3_SHIFT-1:0] prod;
        logic [bstr_pkg::SUB_W-1:0]                  sub_next;
        logic [bstr_pkg::SUB_W-1:0]                  left;
        logic [2:0]                                  digit;
        logic [bstr_pkg::NODE_W-1:0]                 acc_next;

        if (j == 0) begin : g_first
            assign vin = in_valid;
            assign sin = in_idx[bstr_pkg::IDX_W-1:bstr_pkg::SUB_LO];
            assign ain = '0;
            assign iin = in_idx;
            assign bin = in_bad;
        end else begin : g_rest
            assign vin = valid_reg[j-1];
            assign sin = sub_reg[j-1];
            assign ain = acc_reg[j-1];
            assign iin = idx_reg[j-1];
            assign bin = bad_reg[j-1];
        end

        // Divide the sub-cube number by three through its reciprocal
        assign prod = (bstr_pkg::SUB_W+bstr_pkg::DIV3_SHIFT)'(sin)
                    * (bstr_pkg::SUB_W+bstr_pkg::DIV3_SHIFT)'(bstr_pkg::DIV3_MUL);
        assign sub_next = prod[bstr_pkg::SUB_W+bstr_pkg::DIV3_SHIFT-1:bstr_pkg::DIV3_SHIFT];
        assign left     = sin - sub_next - {sub_next[bstr_pkg::SUB_W-2:0], 1'b0};
        // Coordinate on this axis: sub-cube origin plus the inner bit
        assign digit    = {left[1:0], iin[bstr_pkg::SLOT_BITS + j]};
        assign acc_next = ain + bstr_pkg::NODE_W'(bstr_pkg::NODE_W'(digit)
                        * bstr_pkg::NODE_W'(bstr_pkg::pow6(j)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            sub_reg[j] <= sub_next;
            acc_reg[j] <= acc_next;
            idx_reg[j] <= iin;
            bad_reg[j] <= bin;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_idx   = idx_reg[N-1];
    assign out_bad   = bad_reg[N-1];
    assign out_trank = {acc_reg[N-1], idx_reg[N-1][bstr_pkg::SLOT_BITS-1:0]};

endmodule

// ----- design/bstr_cfg.sv -----
// APB register file and derived configuration (group counts, products, error flag).
// Depends on bstr_pkg and bstr_div_pipe.
module bstr_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output bstr_pkg::cfg_t        cfg,
    output logic                  busy
);

    logic [bstr_pkg::RC_W-1:0]    rank_count_reg;
    logic [bstr_pkg::GRID_W-1:0]  grid_x_reg, grid_y_reg, grid_z_reg;
    logic [bstr_pkg::BLK_W-1:0]   blk_x_reg, blk_y_reg, blk_z_reg;
    logic [bstr_pkg::GC_W-1:0]    gc_x_reg, gc_y_reg, gc_z_reg;
    logic [bstr_pkg::BXY_W-1:0]   blk_xy_reg;
    logic [bstr_pkg::CELLS_W-1:0] cells_reg;
    logic [bstr_pkg::GXY_W-1:0]   gc_xy_reg;
    logic [bstr_pkg::GXGY_W-1:0]  grid_xy_reg;
    logic                         bad_reg;
    logic [bstr_pkg::SETTLE_W-1:0] settle_reg;

    logic                          wr;
    logic [bstr_pkg::REG_IDX_W-1:0] idx;
    logic [bstr_pkg::GRID_W-1:0]   q_x, q_y, q_z;

    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg <= bstr_pkg::RC_W'(1);
            grid_x_reg     <= bstr_pkg::GRID_W'(4);
            grid_y_reg     <= bstr_pkg::GRID_W'(4);
            grid_z_reg     <= bstr_pkg::GRID_W'(4);
            blk_x_reg      <= bstr_pkg::BLK_W'(1);
            blk_y_reg      <= bstr_pkg::BLK_W'(1);
            blk_z_reg      <= bstr_pkg::BLK_W'(1);
            settle_reg     <= bstr_pkg::SETTLE_W'(bstr_pkg::SETTLE_CYCLES);
        end
        else
        begin
            if (wr)
            begin
                case (idx)
                    bstr_pkg::REG_RANK_COUNT: rank_count_reg <= pwdata[bstr_pkg::RC_W-1:0];
                    bstr_pkg::REG_GRID_X:     grid_x_reg     <= pwdata[bstr_pkg::GRID_W-1:0];
                    bstr_pkg::REG_GRID_Y:     grid_y_reg     <= pwdata[bstr_pkg::GRID_W-1:0];
                    bstr_pkg::REG_GRID_Z:     grid_z_reg     <= pwdata[bstr_pkg::GRID_W-1:0];
                    bstr_pkg::REG_BLOCK_X:    blk_x_reg      <= pwdata[bstr_pkg::BLK_W-1:0];
                    bstr_pkg::REG_BLOCK_Y:    blk_y_reg      <= pwdata[bstr_pkg::BLK_W-1:0];
                    bstr_pkg::REG_BLOCK_Z:    blk_z_reg      <= pwdata[bstr_pkg::BLK_W-1:0];
                    default: ;
                endcase
                settle_reg <= bstr_pkg::SETTLE_W'(bstr_pkg::SETTLE_CYCLES);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        case (idx)
            bstr_pkg::REG_RANK_COUNT: prdata = 32'(rank_count_reg);
            bstr_pkg::REG_GRID_X:     prdata = 32'(grid_x_reg);
            bstr_pkg::REG_GRID_Y:     prdata = 32'(grid_y_reg);
            bstr_pkg::REG_GRID_Z:     prdata = 32'(grid_z_reg);
            bstr_pkg::REG_BLOCK_X:    prdata = 32'(blk_x_reg);
            bstr_pkg::REG_BLOCK_Y:    prdata = 32'(blk_y_reg);
            bstr_pkg::REG_BLOCK_Z:    prdata = 32'(blk_z_reg);
            default:                  prdata = '0;
        endcase
    end

    // Groups per axis: grid / (GROUP_EDGE * block), recomputed continuously
    bstr_div_pipe #(.Q(bstr_pkg::GRID_W), .DW(bstr_pkg::GRID_W), .PW(1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(1'b1), .in_hi('0), .in_lo(grid_x_reg),
        .den({blk_x_reg, {bstr_pkg::GROUP_BITS{1'b0}}}), .in_pay(1'b0),
        .out_valid(), .quot(q_x), .rem(), .out_pay()
    );
    bstr_div_pipe #(.Q(bstr_pkg::GRID_W), .DW(bstr_pkg::GRID_W), .PW(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(1'b1), .in_hi('0), .in_lo(grid_y_reg),
        .den({blk_y_reg, {bstr_pkg::GROUP_BITS{1'b0}}}), .in_pay(1'b0),
        .out_valid(), .quot(q_y), .rem(), .out_pay()
    );
    bstr_div_pipe #(.Q(bstr_pkg::GRID_W), .DW(bstr_pkg::GRID_W), .PW(1)) u_div_z (
        .clk(clk), .rst_n(rst_n), .in_valid(1'b1), .in_hi('0), .in_lo(grid_z_reg),
        .den({blk_z_reg, {bstr_pkg::GROUP_BITS{1'b0}}}), .in_pay(1'b0),
        .out_valid(), .quot(q_z), .rem(), .out_pay()
    );

    always_ff @(posedge clk)
    begin
        gc_x_reg    <= q_x[bstr_pkg::GC_W-1:0];
        gc_y_reg    <= q_y[bstr_pkg::GC_W-1:0];
        gc_z_reg    <= q_z[bstr_pkg::GC_W-1:0];
        gc_xy_reg   <= bstr_pkg::GXY_W'(gc_x_reg) * bstr_pkg::GXY_W'(gc_y_reg);
        blk_xy_reg  <= bstr_pkg::BXY_W'(blk_x_reg) * bstr_pkg::BXY_W'(blk_y_reg);
        cells_reg   <= bstr_pkg::CELLS_W'(blk_xy_reg) * bstr_pkg::CELLS_W'(blk_z_reg);
        grid_xy_reg <= bstr_pkg::GXGY_W'(grid_x_reg) * bstr_pkg::GXGY_W'(grid_y_reg);
        bad_reg     <= (blk_x_reg == '0) || (blk_y_reg == '0) || (blk_z_reg == '0)
                    || (gc_x_reg == '0) || (gc_y_reg == '0) || (gc_z_reg == '0);
    end

    assign cfg.rank_count = rank_count_reg;
    assign cfg.grid_x     = grid_x_reg;
    assign cfg.grid_xy    = grid_xy_reg;
    assign cfg.blk_x      = blk_x_reg;
    assign cfg.blk_y      = blk_y_reg;
    assign cfg.blk_z      = blk_z_reg;
    assign cfg.blk_xy     = blk_xy_reg;
    assign cfg.cells      = cells_reg;
    assign cfg.gc_x       = gc_x_reg;
    assign cfg.gc_xy      = gc_xy_reg;
    assign cfg.bad        = bad_reg;

    assign busy = (settle_reg != '0);

endmodule

// ----- design/blocked_stencil_torus_rank_map_core.sv -----
// Top level of the blocked stencil / 6-D torus rank map.
// Depends on bstr_pkg, bstr_div_pipe, bstr_torus and bstr_cfg.
//
// A task index is taken at a rising edge where start is high and busy is low. Its result
// is then on the ports for one cycle with done high. A new index may be taken in every
// cycle, so one transaction per cycle is sustained. The pipeline is the entry register, the
// six torus digit stages, the group divider (14 stages, one quotient bit each), the
// group-coordinate dividers behind it (14 + 7 stages, as long as the block and cell
// dividers with their hold register) and three compose stages (multiply-add, grid-stride
// multiply, final sum). The receiver cannot stall, so no result is ever held back. After
// reset and after every register write, busy stays high while the derived configuration
// (groups per axis, cell and grid products) settles; write registers only while no
// transaction is in flight.
module blocked_stencil_torus_rank_map_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bstr_pkg::IDX_W-1:0]      task_index,
    output logic                            done,
    output logic [bstr_pkg::STENCIL_W-1:0]  stencil_rank,
    output logic [bstr_pkg::TRANK_W-1:0]    torus_rank,
    output logic                            invalid,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [4:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IW  = bstr_pkg::IDX_W;
    localparam int SW  = bstr_pkg::STENCIL_W;
    localparam int TW  = bstr_pkg::TRANK_W;
    localparam int GB  = bstr_pkg::GROUP_BITS;
    localparam int CB  = bstr_pkg::CUBE_BITS;
    localparam int BW  = bstr_pkg::BLK_W;
    localparam int GCW = bstr_pkg::GC_W;
    localparam int GNW = bstr_pkg::GNUM_W;
    localparam int XW  = GCW + GB + BW;          // x or y cell coordinate

    bstr_pkg::cfg_t cfg;
    logic           accept;

    bstr_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cfg(cfg), .busy(busy)
    );

    assign accept = start & ~busy;

    // Entry stage: capture the index and decide up front whether it maps at all
    logic          in_valid_reg;
    logic [IW-1:0] in_idx_reg;
    logic          in_bad_reg;
    logic          in_bad_next;

    assign in_bad_next = cfg.bad || (task_index >= cfg.rank_count)
                      || (task_index >= IW'(bstr_pkg::TORUS_TOTAL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        in_idx_reg <= task_index;
        in_bad_reg <= in_bad_next;
    end

    // Torus rank
    logic          t_valid;
    logic [IW-1:0] t_idx;
    logic          t_bad;
    logic [TW-1:0] t_trank;

    bstr_torus u_torus (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid_reg), .in_idx(in_idx_reg),
        .in_bad(in_bad_reg), .out_valid(t_valid), .out_idx(t_idx), .out_bad(t_bad),
        .out_trank(t_trank)
    );

    // Split the index into group number and position within the group
    logic                          d1_valid;
    logic [GNW-1:0]                d1_gnum;
    logic [bstr_pkg::GROUP_W-1:0]  d1_rem;
    logic [TW:0]                   d1_pay;
    logic [IW-1:0]                 grp_pos;

    bstr_div_pipe #(.Q(GNW), .DW(bstr_pkg::GROUP_W), .PW(TW + 1)) u_div_group (
        .clk(clk), .rst_n(rst_n), .in_valid(t_valid),
        .in_hi(bstr_pkg::GROUP_W'(t_idx[IW-1:GNW])), .in_lo(t_idx[GNW-1:0]),
        .den({cfg.cells, {CB{1'b0}}}), .in_pay({t_bad, t_trank}),
        .out_valid(d1_valid), .quot(d1_gnum), .rem(d1_rem), .out_pay(d1_pay)
    );

    assign grp_pos = d1_rem[IW-1:0];

    // Branch A: block number within the group, then cell coordinates within the block
    logic                          d2_valid;
    logic [CB-1:0]                 d2_bnum;
    logic [bstr_pkg::CELLS_W-1:0]  d2_rem;
    logic                          d2_bad;

    bstr_div_pipe #(.Q(CB), .DW(bstr_pkg::CELLS_W), .PW(1)) u_div_block (
        .clk(clk), .rst_n(rst_n), .in_valid(d1_valid),
        .in_hi(bstr_pkg::CELLS_W'(grp_pos[IW-1:CB])), .in_lo(grp_pos[CB-1:0]),
        .den(cfg.cells), .in_pay(d1_pay[TW]),
        .out_valid(d2_valid), .quot(d2_bnum), .rem(d2_rem), .out_pay(d2_bad)
    );

    logic                        d3_valid;
    logic [BW-1:0]               d3_cz;
    logic [bstr_pkg::BXY_W-1:0]  d3_rem;
    logic [CB:0]                 d3_pay;

    bstr_div_pipe #(.Q(BW), .DW(bstr_pkg::BXY_W), .PW(CB + 1)) u_div_cz (
        .clk(clk), .rst_n(rst_n), .in_valid(d2_valid),
        .in_hi(bstr_pkg::BXY_W'(d2_rem[IW-1:BW])), .in_lo(d2_rem[BW-1:0]),
        .den(cfg.blk_xy), .in_pay({d2_bad, d2_bnum}),
        .out_valid(d3_valid), .quot(d3_cz), .rem(d3_rem), .out_pay(d3_pay)
    );

    logic                d4_valid;
    logic [BW-1:0]       d4_cy;
    logic [BW-1:0]       d4_cx;
    logic [CB+BW:0]      d4_pay;

    bstr_div_pipe #(.Q(BW), .DW(BW), .PW(CB + BW + 1)) u_div_cy (
        .clk(clk), .rst_n(rst_n), .in_valid(d3_valid),
        .in_hi(d3_rem[2*BW-1:BW]), .in_lo(d3_rem[BW-1:0]),
        .den(cfg.blk_x), .in_pay({d3_pay, d3_cz}),
        .out_valid(d4_valid), .quot(d4_cy), .rem(d4_cx), .out_pay(d4_pay)
    );

    // Branch B: group coordinates in the grid
    logic                        d5_valid;
    logic [GNW-1:0]              d5_gz;
    logic [bstr_pkg::GXY_W-1:0]  d5_rem;
    logic [TW-1:0]               d5_trank;

    bstr_div_pipe #(.Q(GNW), .DW(bstr_pkg::GXY_W), .PW(TW)) u_div_gz (
        .clk(clk), .rst_n(rst_n), .in_valid(d1_valid), .in_hi('0), .in_lo(d1_gnum),
        .den(cfg.gc_xy), .in_pay(d1_pay[TW-1:0]),
        .out_valid(d5_valid), .quot(d5_gz), .rem(d5_rem), .out_pay(d5_trank)
    );

    logic                d6_valid;
    logic [GCW-1:0]      d6_gy;
    logic [GCW-1:0]      d6_gx;
    logic [TW+GNW-1:0]   d6_pay;

    bstr_div_pipe #(.Q(GCW), .DW(GCW), .PW(TW + GNW)) u_div_gy (
        .clk(clk), .rst_n(rst_n), .in_valid(d5_valid),
        .in_hi(d5_rem[2*GCW-1:GCW]), .in_lo(d5_rem[GCW-1:0]),
        .den(cfg.gc_x), .in_pay({d5_trank, d5_gz}),
        .out_valid(d6_valid), .quot(d6_gy), .rem(d6_gx), .out_pay(d6_pay)
    );

    // Hold branch A in a register stage so it lines up with branch B
    logic          a_valid_reg;
    logic          a_bad_reg;
    logic [CB-1:0] a_bnum_reg;
    logic [BW-1:0] a_cz_reg, a_cy_reg, a_cx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= d4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_bad_reg  <= d4_pay[CB+BW];
        a_bnum_reg <= d4_pay[CB+BW-1:BW];
        a_cz_reg   <= d4_pay[BW-1:0];
        a_cy_reg   <= d4_cy;
        a_cx_reg   <= d4_cx;
    end

    // Compose stage 1: cell coordinates x, y, z
    logic [GCW+GB-1:0] xi, yi;
    logic [GNW+GB-1:0] zi;
    logic [XW-1:0]     x1_next, y1_next;
    logic [SW-1:0]     z1_next;

    assign xi = {d6_gx, a_bnum_reg[GB-1:0]};
    assign yi = {d6_gy, a_bnum_reg[2*GB-1:GB]};
    assign zi = {d6_pay[GNW-1:0], a_bnum_reg[3*GB-1:2*GB]};

    assign x1_next = XW'(XW'(xi) * XW'(cfg.blk_x)) + XW'(a_cx_reg);
    assign y1_next = XW'(XW'(yi) * XW'(cfg.blk_y)) + XW'(a_cy_reg);
    assign z1_next = SW'(SW'(zi) * SW'(cfg.blk_z)) + SW'(a_cz_reg);

    logic          s1_valid_reg;
    logic          s1_bad_reg;
    logic [TW-1:0] s1_trank_reg;
    logic [XW-1:0] s1_x_reg, s1_y_reg;
    logic [SW-1:0] s1_z_reg;

    // Compose stage 2: scale y and z by the grid strides
    logic          s2_valid_reg;
    logic          s2_bad_reg;
    logic [TW-1:0] s2_trank_reg;
    logic [XW-1:0] s2_x_reg;
    logic [SW-1:0] s2_py_reg, s2_pz_reg;
    logic [SW-1:0] py_next, pz_next;

    assign py_next = SW'(s1_y_reg) * SW'(cfg.grid_x);
    assign pz_next = s1_z_reg * SW'(cfg.grid_xy);

    // Output register
    logic          done_reg;
    logic [SW-1:0] stencil_rank_reg;
    logic [TW-1:0] torus_rank_reg;
    logic          invalid_reg;
    logic [SW-1:0] stencil_next;

    assign stencil_next = SW'(s2_x_reg) + s2_py_reg + s2_pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= d6_valid;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bad_reg   <= a_bad_reg;
        s1_trank_reg <= d6_pay[TW+GNW-1:GNW];
        s1_x_reg     <= x1_next;
        s1_y_reg     <= y1_next;
        s1_z_reg     <= z1_next;

        s2_bad_reg   <= s1_bad_reg;
        s2_trank_reg <= s1_trank_reg;
        s2_x_reg     <= s1_x_reg;
        s2_py_reg    <= py_next;
        s2_pz_reg    <= pz_next;

        // Drop both ranks for an index that cannot be mapped
        invalid_reg      <= s2_bad_reg;
        stencil_rank_reg <= s2_bad_reg ? '0 : stencil_next;
        torus_rank_reg   <= s2_bad_reg ? '0 : s2_trank_reg;
    end

    assign done         = done_reg;
    assign stencil_rank = stencil_rank_reg;
    assign torus_rank   = torus_rank_reg;
    assign invalid      = invalid_reg;

    // The two divider branches must deliver the same transaction in the same cycle
    a_branch_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg == d6_valid)
        else $error("stencil divider branches out of step");

    // A rejected index carries no rank
    invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && invalid |-> stencil_rank == '0 && torus_rank == '0)
        else $error("invalid result with nonzero rank");

    // A register write holds off new transactions while derived values settle
    cfg_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> busy)
        else $error("busy not raised after register write");

endmodule
